// ===== rtl/core/skt_pkg.sv =====
package skt_pkg;

  localparam int KEY_W = 32;
  localparam int PAY_IO_W = 16;
  localparam int COUNT_IO_W = 7;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]              operation;
    logic signed [KEY_W-1:0] key;
    logic [PAY_IO_W-1:0]     payload;
  } skt_req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [PAY_IO_W-1:0]   payload_out;
    logic [COUNT_IO_W-1:0] entry_count;
    logic                  is_empty;
  } skt_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_HEAD,
    ST_SEARCH,
    ST_SHIFT,
    ST_DONE
  } skt_state_t;

endpackage

// ===== rtl/core/sorted_key_table.sv =====
// Ordered table of up to DEPTH entries, each a signed key and a payload handle, held in
// ascending key order in a single memory with one write and one registered read port. One
// request is worked on at a time; the next is taken once the previous result sits in the
// response register, even while that response is stalled. Entries are visited one at a time
// through the memory read port. Insert walks down from the top entry, moving up by one each
// entry with a larger key, or an equal key above entry 0. Lookup walks up from entry 0 and
// stops at the first match or after the last entry. Remove searches the same way and then
// moves every later entry down by one. Insert into a full table, any request on an empty
// table and the unused operation code go straight to the result without visiting an entry.
// No clearing pass is needed after reset.
module sorted_key_table
  import skt_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int PAYLOAD_WIDTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  skt_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output skt_rsp_t rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int ENTRY_W = KEY_W + PAYLOAD_WIDTH;

  skt_state_t state, state_next;

  logic [CW-1:0]            occ, occ_next;
  logic [1:0]               cmd_op;
  logic signed [KEY_W-1:0]  cmd_key;
  logic [PAYLOAD_WIDTH-1:0] cmd_pay;
  logic [AW-1:0]            rd_idx, rd_idx_next;
  logic [1:0]               res_status, res_status_next;
  logic [PAY_IO_W-1:0]      res_payload, res_payload_next;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [ENTRY_W-1:0] mem_wd;
  logic [AW-1:0]      mem_ra;

  logic                     req_fire;
  logic                     slot_free;
  logic signed [KEY_W-1:0]  rd_key;
  logic [PAYLOAD_WIDTH-1:0] rd_pay;
  logic [CW-1:0]            idx_inc;
  logic                     more;
  logic                     key_hit;
  logic                     move_up;
  logic                     full;

  assign req_stall = (state != ST_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign slot_free = !rsp_valid || !rsp_stall;

  assign rd_key  = rd_data[ENTRY_W-1 -: KEY_W];
  assign rd_pay  = rd_data[PAYLOAD_WIDTH-1:0];
  assign idx_inc = CW'(rd_idx) + CW'(1);
  assign more    = idx_inc < occ;
  assign key_hit = (rd_key == cmd_key);
  assign move_up = (rd_idx != '0) ? (rd_key >= cmd_key) : (rd_key > cmd_key);
  assign full    = (occ == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[mem_ra];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          if ((req.operation == OP_INSERT) && !full && (occ != '0)) begin
            state_next = ST_INSERT;
          end else if (((req.operation == OP_REMOVE) || (req.operation == OP_LOOKUP)) &&
                       (occ != '0)) begin
            state_next = ST_SEARCH;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_INSERT: begin
        if (!move_up) begin
          state_next = ST_DONE;
        end else if (rd_idx == '0) begin
          state_next = ST_HEAD;
        end
      end
      ST_HEAD: state_next = ST_DONE;
      ST_SEARCH: begin
        if (key_hit) begin
          if ((cmd_op == OP_REMOVE) && more) begin
            state_next = ST_SHIFT;
          end else begin
            state_next = ST_DONE;
          end
        end else if (!more) begin
          state_next = ST_DONE;
        end
      end
      ST_SHIFT: begin
        if (!more) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we           = 1'b0;
    mem_wa           = '0;
    mem_wd           = {cmd_key, cmd_pay};
    mem_ra           = rd_idx;
    rd_idx_next      = rd_idx;
    occ_next         = occ;
    res_status_next  = res_status;
    res_payload_next = res_payload;
    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          res_status_next  = STATUS_OK;
          res_payload_next = '0;
          if (req.operation == OP_INSERT) begin
            if (full) begin
              res_status_next = STATUS_FULL;
            end else if (occ == '0) begin
              mem_we   = 1'b1;
              mem_wd   = {req.key, PAYLOAD_WIDTH'(req.payload)};
              occ_next = CW'(1);
            end else begin
              mem_ra      = AW'(occ - CW'(1));
              rd_idx_next = AW'(occ - CW'(1));
            end
          end else if ((req.operation == OP_REMOVE) || (req.operation == OP_LOOKUP)) begin
            mem_ra      = '0;
            rd_idx_next = '0;
            if (occ == '0) begin
              res_status_next = STATUS_NOT_FOUND;
            end
          end
        end
      end
      ST_INSERT: begin
        mem_we = 1'b1;
        mem_wa = rd_idx + AW'(1);
        if (move_up) begin
          mem_wd = rd_data;
          if (rd_idx != '0) begin
            mem_ra      = rd_idx - AW'(1);
            rd_idx_next = rd_idx - AW'(1);
          end
        end else begin
          occ_next = occ + CW'(1);
        end
      end
      ST_HEAD: begin
        mem_we   = 1'b1;
        mem_wa   = '0;
        occ_next = occ + CW'(1);
      end
      ST_SEARCH: begin
        if (key_hit) begin
          if (cmd_op == OP_LOOKUP) begin
            res_payload_next = PAY_IO_W'(rd_pay);
          end else if (more) begin
            mem_ra      = rd_idx + AW'(1);
            rd_idx_next = rd_idx + AW'(1);
          end else begin
            occ_next = occ - CW'(1);
          end
        end else if (more) begin
          mem_ra      = rd_idx + AW'(1);
          rd_idx_next = rd_idx + AW'(1);
        end else begin
          res_status_next = STATUS_NOT_FOUND;
        end
      end
      ST_SHIFT: begin
        mem_we = 1'b1;
        mem_wa = rd_idx - AW'(1);
        mem_wd = rd_data;
        if (more) begin
          mem_ra      = rd_idx + AW'(1);
          rd_idx_next = rd_idx + AW'(1);
        end else begin
          occ_next = occ - CW'(1);
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      occ       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      if ((state == ST_DONE) && slot_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx      <= rd_idx_next;
    res_status  <= res_status_next;
    res_payload <= res_payload_next;
    if (req_fire) begin
      cmd_op  <= req.operation;
      cmd_key <= req.key;
      cmd_pay <= PAYLOAD_WIDTH'(req.payload);
    end
    if ((state == ST_DONE) && slot_free) begin
      rsp.status      <= res_status;
      rsp.payload_out <= res_payload;
      rsp.entry_count <= COUNT_IO_W'(occ);
      rsp.is_empty    <= (occ == '0);
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(DEPTH))
    else $error("Entry count exceeds the table depth.");

  a_occ_change: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (occ != $past(occ))) |-> (state == ST_DONE))
    else $error("Entry count changed other than at the end of a request.");

  a_write_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (CW'(mem_wa) <= occ))
    else $error("Memory write beyond the occupied entries.");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status == STATUS_FULL)) |-> (rsp.entry_count == COUNT_IO_W'(DEPTH)))
    else $error("Full status reported with a table that is not full.");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> (state != ST_IDLE))
    else $error("Accepted request did not start work.");

endmodule

// ===== test/skt_table_checker.sv =====
module skt_table_checker
  import skt_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     req_stall,
  input  skt_req_t req,
  input  logic     rsp_valid,
  input  logic     rsp_stall,
  input  skt_rsp_t rsp,
  output int       fail_count,
  output int       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [KEY_W-1:0] table_keys [DEPTH];
  logic [PAY_IO_W-1:0]     table_pays [DEPTH];
  int                      table_count;
  skt_rsp_t                expected_rsps [$];
  skt_rsp_t                due_rsp;
  int                      rsp_index;

  task automatic report_mismatch(string msg);
    $display("ERROR: %s", msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d: %s is %0h, expected %0h", rsp_index, name,
                                got, want));
    end
  endtask

  // Applies one request to the table and returns the result it must produce.
  function automatic skt_rsp_t apply_table_op(skt_req_t r);
    skt_rsp_t                res;
    logic signed [KEY_W-1:0] k;
    int                      pos;
    int                      i;
    res = '0;
    k = r.key;
    case (r.operation)
      OP_INSERT: begin
        if (table_count >= DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          if (table_count == 0 || table_keys[0] > k) begin
            pos = 0;
          end else begin
            pos = 1;
            while (pos < table_count && table_keys[pos] < k) pos++;
          end
          for (i = table_count; i > pos; i--) begin
            table_keys[i] = table_keys[i-1];
            table_pays[i] = table_pays[i-1];
          end
          table_keys[pos] = k;
          table_pays[pos] = r.payload;
          table_count++;
        end
      end
      OP_REMOVE, OP_LOOKUP: begin
        pos = 0;
        while (pos < table_count && table_keys[pos] != k) pos++;
        if (pos >= table_count) begin
          res.status = STATUS_NOT_FOUND;
        end else if (r.operation == OP_LOOKUP) begin
          res.payload_out = table_pays[pos];
        end else begin
          for (i = pos; i + 1 < table_count; i++) begin
            table_keys[i] = table_keys[i+1];
            table_pays[i] = table_pays[i+1];
          end
          table_count--;
        end
      end
      default: res.status = STATUS_OK;
    endcase
    res.entry_count = table_count[COUNT_IO_W-1:0];
    res.is_empty = (table_count == 0);
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      table_count = 0;
      expected_rsps.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                    rsp_index));
        end else begin
          due_rsp = expected_rsps.pop_front();
          check_field("status", 32'(rsp.status), 32'(due_rsp.status));
          check_field("payload_out", 32'(rsp.payload_out), 32'(due_rsp.payload_out));
          check_field("entry_count", 32'(rsp.entry_count), 32'(due_rsp.entry_count));
          check_field("is_empty", 32'(rsp.is_empty), 32'(due_rsp.is_empty));
        end
        rsp_index++;
      end
      if (req_valid && !req_stall) begin
        expected_rsps.push_back(apply_table_op(req));
      end
    end
    pending <= expected_rsps.size();
  end

endmodule

// ===== test/tb_sorted_key_table.sv =====
module tb_sorted_key_table;
  timeunit 1ns;
  timeprecision 1ps;
  import skt_pkg::*;

  localparam int DEPTH = 64;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 100;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  skt_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  skt_rsp_t rsp;
  int       fail_count;
  int       pending;
  bit       idle_on = 1'b1;
  bit       hold_pending = 1'b0;

  logic signed [KEY_W-1:0] key_pool [16];
  logic signed [KEY_W-1:0] live_keys [$];

  always #10 clk = ~clk;

  sorted_key_table #(
    .DEPTH(DEPTH),
    .PAYLOAD_WIDTH(PAY_IO_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  skt_table_checker #(
    .DEPTH(DEPTH)
  ) table_check (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .fail_count(fail_count),
    .pending(pending)
  );

  // The key list mirrors which keys are stored, so that removes and lookups mostly hit.
  task automatic send_request(logic [1:0] op, logic signed [KEY_W-1:0] k,
                              logic [PAY_IO_W-1:0] pay);
    skt_req_t r;
    int       idx;
    r.operation = op;
    r.key = k;
    r.payload = pay;
    while (idle_on && $urandom_range(99) < 35) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (op == OP_INSERT && live_keys.size() < DEPTH) begin
      live_keys.push_back(k);
    end else if (op == OP_REMOVE) begin
      idx = 0;
      while (idx < live_keys.size() && live_keys[idx] != k) idx++;
      if (idx < live_keys.size()) live_keys.delete(idx);
    end
  endtask

  function automatic logic signed [KEY_W-1:0] pick_key();
    if (live_keys.size() != 0 && $urandom_range(99) < 60) begin
      return live_keys[$urandom_range(live_keys.size() - 1)];
    end
    if ($urandom_range(99) < 70) return key_pool[$urandom_range(15)];
    return $urandom();
  endfunction

  task automatic run_mix(int count, int insert_pct, int remove_pct, int lookup_pct);
    int         r;
    logic [1:0] op;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < insert_pct) op = OP_INSERT;
      else if (r < insert_pct + remove_pct) op = OP_REMOVE;
      else if (r < insert_pct + remove_pct + lookup_pct) op = OP_LOOKUP;
      else op = OP_UNUSED;
      send_request(op, pick_key(), PAY_IO_W'($urandom_range(65535)));
    end
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : rsp_side
    int hold_left;
    bit hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending && !hold_taken) begin
        hold_left = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else if (idle_on) begin
        rsp_stall <= ($urandom_range(99) < 35);
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = 0;
    key_pool[3] = -1;
    key_pool[4] = 1;
    for (int i = 5; i < 16; i++) key_pool[i] = $urandom();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_request(OP_LOOKUP, KEY_MIN, 16'hFFFF);
    send_request(OP_REMOVE, KEY_MAX, 16'h0000);
    send_request(OP_UNUSED, 0, 16'hFFFF);
    send_request(OP_INSERT, 0, 16'hFFFF);
    send_request(OP_INSERT, 0, 16'h0001);
    send_request(OP_INSERT, KEY_MIN, 16'h0000);
    send_request(OP_INSERT, KEY_MAX, 16'hAAAA);
    send_request(OP_INSERT, 0, 16'h5555);
    send_request(OP_INSERT, -1, 16'h1234);
    send_request(OP_INSERT, 1, 16'h8001);
    send_request(OP_LOOKUP, 0, 16'hFFFF);
    send_request(OP_LOOKUP, KEY_MAX, 16'h0000);
    send_request(OP_LOOKUP, KEY_MIN, 16'h0000);
    send_request(OP_LOOKUP, 7, 16'h0000);
    send_request(OP_REMOVE, 0, 16'h0000);
    send_request(OP_LOOKUP, 0, 16'h0000);
    send_request(OP_REMOVE, 7, 16'h0000);
    send_request(OP_UNUSED, -1, 16'h5A5A);
    send_request(OP_REMOVE, KEY_MIN, 16'h0000);
    send_request(OP_LOOKUP, KEY_MIN, 16'h0000);
    send_request(OP_INSERT, -1, 16'h7E7E);
    send_request(OP_LOOKUP, -1, 16'h0000);

    repeat (2) begin
      run_mix(150, 70, 10, 15);
      run_mix(100, 40, 30, 25);
      run_mix(150, 15, 60, 20);
    end

    drain_results();
    idle_on = 1'b0;
    hold_pending = 1'b1;
    run_mix(30, 50, 20, 25);
    run_mix(200, 40, 30, 25);
    idle_on = 1'b1;
    run_mix(150, 70, 10, 15);
    run_mix(150, 15, 60, 20);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
